// ----- src/derq_pkg.sv -----
// shared types, constants and request codes for the double-ended queue
package derq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = CNT_W + 1;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_REVERSE    = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               has_value;
    logic signed [31:0] pop_value;
    logic [6:0]         count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

// ----- src/double_ended_queue_with_reverse_unit.sv -----
// top level of the double-ended queue with reverse
// each item is captured, executed against the ring store, and its result held until taken
// one item at a time: a new item is accepted only after the last result has been taken,
//   as the one-item sequencer waits around the registered read of the ring store
// reset: front pointer, count and reverse flag clear; store contents undefined
module double_ended_queue_with_reverse_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  derq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output derq_pkg::out_item_t out_data
);

  derq_pkg::dp_cmd_t cmd;

  derq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  derq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- src/derq_ctrl.sv -----
// request sequencer: accept, execute, hold result until taken
module derq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output derq_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

endmodule

// ----- src/derq_dp.sv -----
// ring store, pointers, reverse flag and result register
module derq_dp (
  input  logic                clk,
  input  logic                rst,
  input  derq_pkg::dp_cmd_t   cmd,
  input  derq_pkg::in_item_t  in_data,
  output derq_pkg::out_item_t out_data
);

  localparam int IDX_W = derq_pkg::IDX_W;
  localparam int CNT_W = derq_pkg::CNT_W;
  localparam int SUM_W = derq_pkg::SUM_W;

  function automatic logic [IDX_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    begin
      r = (s >= SUM_W'(derq_pkg::CAPACITY)) ? s - SUM_W'(derq_pkg::CAPACITY) : s;
      return r[IDX_W-1:0];
    end
  endfunction

  logic signed [31:0] mem [derq_pkg::CAPACITY];

  derq_pkg::in_item_t req;
  logic [IDX_W-1:0]   front, front_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               reversed, reversed_next;
  logic signed [31:0] rd_data;
  logic [1:0]         res_status, status_next;
  logic               res_has, has_next;

  logic               is_push, is_pop, at_front, full, empty;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   slot;
  logic [SUM_W-1:0]   tail_sum, back_sum;

  always_comb begin
    is_push  = (req.func == derq_pkg::FUNC_PUSH_FRONT) ||
               (req.func == derq_pkg::FUNC_PUSH_BACK);
    is_pop   = (req.func == derq_pkg::FUNC_POP_FRONT) ||
               (req.func == derq_pkg::FUNC_POP_BACK);
    at_front = ((req.func == derq_pkg::FUNC_PUSH_FRONT) ||
                (req.func == derq_pkg::FUNC_POP_FRONT)) ^ reversed;
    full     = (count == CNT_W'(derq_pkg::CAPACITY));
    empty    = (count == '0);
    tail_sum = SUM_W'(front) + SUM_W'(count);
    back_sum = tail_sum - SUM_W'(1);

    front_next    = front;
    count_next    = count;
    reversed_next = reversed;
    status_next   = derq_pkg::STATUS_OK;
    has_next      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    slot          = front;

    if (is_push) begin
      if (full) begin
        status_next = derq_pkg::STATUS_FULL;
      end else begin
        mem_we     = 1'b1;
        count_next = count + CNT_W'(1);
        if (at_front) begin
          slot       = (front == '0) ? IDX_W'(derq_pkg::CAPACITY - 1) : front - IDX_W'(1);
          front_next = slot;
        end else begin
          slot = ring_wrap(tail_sum);
        end
      end
    end else if (is_pop) begin
      if (empty) begin
        status_next = derq_pkg::STATUS_EMPTY;
      end else begin
        mem_re     = 1'b1;
        has_next   = 1'b1;
        count_next = count - CNT_W'(1);
        if (at_front) begin
          slot       = front;
          front_next = ring_wrap(SUM_W'(front) + SUM_W'(1));
        end else begin
          slot = ring_wrap(back_sum);
        end
      end
    end else if (req.func == derq_pkg::FUNC_REVERSE) begin
      reversed_next = ~reversed;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
    if (cmd.exec) begin
      res_status <= status_next;
      res_has    <= has_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[slot] <= req.push_value;
    end
    if (cmd.exec && mem_re) begin
      rd_data <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      reversed <= 1'b0;
    end else if (cmd.exec) begin
      front    <= front_next;
      count    <= count_next;
      reversed <= reversed_next;
    end
  end

  assign out_data.status    = res_status;
  assign out_data.has_value = res_has;
  assign out_data.pop_value = res_has ? rd_data : 32'sd0;
  assign out_data.count     = 7'(count);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(derq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_push && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("accepted push did not grow the queue");

  a_pop_empty_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_pop && empty) |=> ($stable(front) && count == '0))
    else $error("pop on empty queue changed state");

  a_reverse_toggles: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && req.func == derq_pkg::FUNC_REVERSE) |=>
      (reversed != $past(reversed) && $stable(count)))
    else $error("reverse did not toggle the flag");
`endif

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the double-ended queue with reverse, with a shadow deque as scoreboard
module tb;

  localparam int IDLE_LIMIT  = 4000;
  localparam int RANDOM_REQS = 1226;
  localparam int DRAIN_WAIT  = 10;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_BEAT} stall_mode_t;

  class deque_shadow_t;
    logic signed [31:0]  slots [derq_pkg::CAPACITY];
    int                  head;
    int                  fill;
    logic                flipped;
    derq_pkg::out_item_t expected_replies [$];
    int                  errors;

    function new();
      head = 0;
      fill = 0;
      flipped = 1'b0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_request(derq_pkg::in_item_t req);
      derq_pkg::out_item_t r;
      logic                at_head;
      r = '0;
      r.status = derq_pkg::STATUS_OK;
      case (req.func)
        derq_pkg::FUNC_PUSH_FRONT, derq_pkg::FUNC_PUSH_BACK: begin
          at_head = (req.func == derq_pkg::FUNC_PUSH_FRONT) ^ flipped;
          if (fill >= derq_pkg::CAPACITY) begin
            r.status = derq_pkg::STATUS_FULL;
          end else begin
            if (at_head) begin
              head = (head + derq_pkg::CAPACITY - 1) % derq_pkg::CAPACITY;
              slots[head] = req.push_value;
            end else begin
              slots[(head + fill) % derq_pkg::CAPACITY] = req.push_value;
            end
            fill++;
          end
        end
        derq_pkg::FUNC_POP_FRONT, derq_pkg::FUNC_POP_BACK: begin
          at_head = (req.func == derq_pkg::FUNC_POP_FRONT) ^ flipped;
          if (fill == 0) begin
            r.status = derq_pkg::STATUS_EMPTY;
          end else begin
            if (at_head) begin
              r.pop_value = slots[head];
              head = (head + 1) % derq_pkg::CAPACITY;
            end else begin
              r.pop_value = slots[(head + fill - 1) % derq_pkg::CAPACITY];
            end
            fill--;
            r.has_value = 1'b1;
          end
        end
        derq_pkg::FUNC_REVERSE: begin
          flipped = ~flipped;
        end
        default: begin
        end
      endcase
      r.count = 7'(fill);
      expected_replies.push_back(r);
    endfunction

    function void check_reply(derq_pkg::out_item_t got);
      derq_pkg::out_item_t e;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected item, expected none, got %p", $time, got);
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.has_value !== e.has_value) begin
        $display("%0t: has_value expected %0d got %0d", $time, e.has_value, got.has_value);
        errors++;
      end
      if (got.pop_value !== e.pop_value) begin
        $display("%0t: pop_value expected %0d got %0d", $time, e.pop_value, got.pop_value);
        errors++;
      end
      if (got.count !== e.count) begin
        $display("%0t: count expected %0d got %0d", $time, e.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  derq_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  derq_pkg::out_item_t out_data;

  deque_shadow_t sb = new();
  int            idle_cycles = 0;
  int            burst_left = 0;
  stall_mode_t   stall_mode = STALL_NONE;
  int            stall_left = 0;
  int            beat = 0;

  always #6 clk = ~clk;

  double_ended_queue_with_reverse_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_request(in_data);
    if (!rst && out_valid && !out_stall) sb.check_reply(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver back-pressure in modes of random length
  always @(posedge clk) begin
    logic next_stall;
    next_stall = 1'b0;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        STALL_COIN:  next_stall = 1'($urandom_range(0, 1));
        STALL_HEAVY: next_stall = ($urandom_range(0, 99) < 80);
        STALL_BEAT:  next_stall = (beat % 3 != 0);
        default:     next_stall = 1'b0;
      endcase
    end
    beat <= beat + 1;
    out_stall <= next_stall;
  end

  task automatic send_item(logic [2:0] func, logic signed [31:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data.func <= func;
    in_data.push_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_func(int push_pct, int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return 3'($urandom_range(5, 7));
    if (roll < 2 + push_pct)
      return $urandom_range(0, 1) ? derq_pkg::FUNC_PUSH_BACK : derq_pkg::FUNC_PUSH_FRONT;
    if (roll < 2 + push_pct + pop_pct)
      return $urandom_range(0, 1) ? derq_pkg::FUNC_POP_BACK : derq_pkg::FUNC_POP_FRONT;
    return derq_pkg::FUNC_REVERSE;
  endfunction

  initial begin
    int counted;
    int phase;
    int phase_len;
    int push_pct;
    int pop_pct;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty queue corners, ignored codes, extreme values and reverse on both ends
    send_item(derq_pkg::FUNC_POP_FRONT, 32'sd0);
    send_item(derq_pkg::FUNC_POP_BACK, 32'sd0);
    send_item(derq_pkg::FUNC_REVERSE, 32'sd0);
    send_item(derq_pkg::FUNC_POP_FRONT, 32'sd0);
    send_item(derq_pkg::FUNC_REVERSE, 32'sd0);
    send_item(3'd5, 32'sh12345678);
    send_item(3'd6, -32'sd1);
    send_item(3'd7, 32'sh7fffffff);
    send_item(derq_pkg::FUNC_PUSH_FRONT, 32'sh7fffffff);
    send_item(derq_pkg::FUNC_PUSH_BACK, 32'sh80000000);
    send_item(derq_pkg::FUNC_PUSH_FRONT, 32'sd0);
    send_item(derq_pkg::FUNC_PUSH_BACK, -32'sd1);
    send_item(3'd5, 32'sd0);
    send_item(derq_pkg::FUNC_REVERSE, 32'sd0);
    send_item(derq_pkg::FUNC_POP_FRONT, 32'sd0);
    send_item(derq_pkg::FUNC_PUSH_FRONT, 32'sh55555555);
    send_item(derq_pkg::FUNC_PUSH_BACK, 32'shaaaaaaaa);
    send_item(derq_pkg::FUNC_POP_BACK, 32'sd0);
    send_item(derq_pkg::FUNC_REVERSE, 32'sd0);
    send_item(derq_pkg::FUNC_POP_BACK, 32'sd0);
    send_item(derq_pkg::FUNC_POP_FRONT, 32'sd0);
    send_item(derq_pkg::FUNC_POP_BACK, 32'sd0);
    send_item(derq_pkg::FUNC_POP_FRONT, 32'sd0);
    send_item(derq_pkg::FUNC_POP_BACK, 32'sd0);

    counted = 0;
    phase = 0;
    while (counted < RANDOM_REQS) begin
      case ((phase < 3) ? phase : $urandom_range(0, 2))
        0: begin push_pct = 85; pop_pct = 8; end
        1: begin push_pct = 8; pop_pct = 85; end
        default: begin push_pct = 45; pop_pct = 45; end
      endcase
      phase++;
      phase_len = $urandom_range(30, 150);
      while (phase_len > 0 && counted < RANDOM_REQS) begin
        send_item(pick_func(push_pct, pop_pct), pick_value());
        counted++;
        phase_len--;
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- double_ended_queue_with_reverse_unit.f -----
src/derq_pkg.sv
src/derq_ctrl.sv
src/derq_dp.sv
src/double_ended_queue_with_reverse_unit.sv
verif/tb.sv
